// ===== design/vsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants of the dual three-phase VSD transform
// Item formats, fixed-point constants, pipeline control bundle and the
// quarter-wave sine entry function used to fill the lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package vsd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int TRIG_WIDTH   = 16;
	localparam int ENTRY_WIDTH  = 15;
	localparam int NUM_STAGES   = 8;

	// sqrt(3)/2 in Q14, and the Q14 weight of one half as a shift
	localparam logic signed [15:0] ROOT3_HALF_Q14 = 16'sd14189;
	localparam int HALF_Q14_SHIFT = 13;

	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] SINE_AMPLITUDE = 64'd32767;

	// divisors (2i)(2i+1) of the Taylor terms, term i at index i
	localparam logic [6:1][7:0] TAYLOR_DEN = {8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [ANGLE_WIDTH-1:0] angle_t;
	typedef logic signed [TRIG_WIDTH-1:0] trig_t;

	localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef struct packed {
		sample_t first_a_current;
		sample_t first_b_current;
		sample_t first_c_current;
		sample_t second_a_current;
		sample_t second_b_current;
		sample_t second_c_current;
		angle_t  rotor_angle;
	} in_item_t;

	typedef struct packed {
		sample_t d_current;
		sample_t q_current;
		sample_t x_current;
		sample_t y_current;
	} out_item_t;

	// per-stage load enables and valid bits
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctrl_t;

	// Quarter-wave sine entry: seven-term Taylor series in unsigned Q30 with
	// truncating steps, scaled to 32767 and rounded. Evaluated at elaboration.
	function automatic logic [ENTRY_WIDTH-1:0] sine_entry(input int unsigned k,
			input int unsigned tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		int i;
		x = (64'(k) * HALF_PI_Q30) >> tbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (i = 1; i <= 6; i++) begin
			term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[i]);
			if (i[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		v = (sum * signed'(SINE_AMPLITUDE) + (64'sd1 <<< 29)) >>> 30;
		if (v > signed'(SINE_AMPLITUDE)) begin
			v = signed'(SINE_AMPLITUDE);
		end
		return v[ENTRY_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/vsd_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// vsd_pipe_ctrl: valid/stall control of the transform pipeline
// Tracks one valid bit per stage and opens a stage whenever it is empty or
// its successor moves, so bubbles close up under a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	input  logic                result_stall,
	output vsd_pkg::pipe_ctrl_t pipe
);
	import vsd_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	logic                  next_ready;

	// stage k may load when it is empty or stage k+1 is loading
	always_comb begin
		next_ready = !result_stall;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || next_ready;
			next_ready = en[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= sample_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pipe.en  = en;
	assign pipe.vld = vld_q;

endmodule

`default_nettype wire

// ===== design/vsd_sine_rom.sv =====
// ----------------------------------------------------------------------------
// vsd_sine_rom: quarter-wave sine lookup over three stages
// Quadrant decode and index mirror, registered table read, sign restore.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_sine_rom #(
	parameter int TABLE_BITS = 10
) (
	input  logic            clk,
	input  logic [2:0]      en,
	input  vsd_pkg::angle_t angle,
	output vsd_pkg::trig_t  value
);
	import vsd_pkg::*;

	localparam int POS_BITS = ANGLE_WIDTH - 2;
	localparam int DEPTH    = (1 << TABLE_BITS) + 1;
	localparam logic [TABLE_BITS:0] QUARTER = (TABLE_BITS + 1)'(1) << TABLE_BITS;

	logic [ENTRY_WIDTH-1:0] rom [0:DEPTH-1];

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_rom
			localparam logic [ENTRY_WIDTH-1:0] ENTRY = sine_entry(k, TABLE_BITS);
			assign rom[k] = ENTRY;
		end
	endgenerate

	logic [1:0]            quad;
	logic [POS_BITS-1:0]   pos;
	logic [TABLE_BITS-1:0] scaled;
	logic [TABLE_BITS:0]   idx;

	assign quad = angle[ANGLE_WIDTH-1 -: 2];
	assign pos  = angle[POS_BITS-1:0];

	generate
		if (POS_BITS >= TABLE_BITS) begin : g_trunc
			assign scaled = TABLE_BITS'(pos >> (POS_BITS - TABLE_BITS));
		end else begin : g_widen
			assign scaled = {pos, {(TABLE_BITS - POS_BITS){1'b0}}};
		end
	endgenerate

	// mirror in the second and fourth quadrants
	assign idx = quad[0] ? (QUARTER - {1'b0, scaled}) : {1'b0, scaled};

	logic [TABLE_BITS:0]    idx_s1;
	logic                   neg_s1;
	logic [ENTRY_WIDTH-1:0] entry_s2;
	logic                   neg_s2;
	trig_t                  value_s3;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			idx_s1 <= idx;
			neg_s1 <= quad[1];
		end
		if (en[1]) begin
			entry_s2 <= rom[idx_s1];
			neg_s2   <= neg_s1;
		end
		if (en[2]) begin
			value_s3 <= neg_s2 ? -signed'({1'b0, entry_s2}) : signed'({1'b0, entry_s2});
		end
	end

	assign value = value_s3;

endmodule

`default_nettype wire

// ===== design/vsd_round_div3.sv =====
// ----------------------------------------------------------------------------
// vsd_round_div3: divide by three with fraction removal and saturation
// Rounds to nearest (ties away from zero) over three stages: bias and
// shift, reciprocal multiply, one-step correction with sign and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module vsd_round_div3 #(
	parameter int NUM_WIDTH = 50,
	parameter int FRAC_BITS = 29
) (
	input  logic                        clk,
	input  logic [2:0]                  en,
	input  logic signed [NUM_WIDTH-1:0] num,
	output vsd_pkg::sample_t            result
);
	import vsd_pkg::*;

	localparam int TW = NUM_WIDTH + 1 - FRAC_BITS;
	localparam logic [NUM_WIDTH:0] OFFSET = (NUM_WIDTH + 1)'(3) << (FRAC_BITS - 1);
	localparam logic [TW-1:0] RECIP     = TW'((64'd1 << TW) / 3);
	localparam logic [TW-1:0] DIVISOR   = TW'(3);
	localparam logic [TW-1:0] POS_LIMIT = TW'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic [TW-1:0] NEG_LIMIT = TW'(64'd1 << (SAMPLE_WIDTH - 1));

	logic [NUM_WIDTH-1:0] mag;
	logic [NUM_WIDTH:0]   biased;
	logic [2*TW-1:0]      prod;
	logic [TW-1:0]        rem;
	logic [TW-1:0]        quo;
	sample_t              sat;

	logic [TW-1:0] t_s6;
	logic          neg_s6;
	logic [TW-1:0] t_s7;
	logic [TW-1:0] q0_s7;
	logic          neg_s7;
	sample_t       result_s8;

	assign mag    = num[NUM_WIDTH-1] ? unsigned'(-num) : unsigned'(num);
	assign biased = {1'b0, mag} + OFFSET;
	assign prod   = (2 * TW)'(t_s6) * (2 * TW)'(RECIP);

	// the reciprocal estimate is low by at most one
	assign rem = t_s7 - (q0_s7 + (q0_s7 << 1));
	assign quo = q0_s7 + TW'(rem >= DIVISOR);

	always_comb begin
		if (!neg_s7 && quo > POS_LIMIT) begin
			sat = SAT_MAX;
		end else if (neg_s7 && quo > NEG_LIMIT) begin
			sat = SAT_MIN;
		end else if (neg_s7) begin
			sat = -signed'(quo[SAMPLE_WIDTH-1:0]);
		end else begin
			sat = signed'(quo[SAMPLE_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s6   <= biased[NUM_WIDTH:FRAC_BITS];
			neg_s6 <= num[NUM_WIDTH-1];
		end
		if (en[1]) begin
			t_s7   <= t_s6;
			q0_s7  <= prod[2*TW-1:TW];
			neg_s7 <= neg_s6;
		end
		if (en[2]) begin
			result_s8 <= sat;
		end
	end

	assign result = result_s8;

endmodule

`default_nettype wire

// ===== design/dual_three_phase_vsd_transform.sv =====
// ----------------------------------------------------------------------------
// dual_three_phase_vsd_transform: vector space decomposition, dual 3-phase
// Six phase currents and a rotor angle in, d/q and x/y currents out.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// returns one result item per input item, in order, through eight register
// stages. Throughput, when not stalled, is one item every cycle, set by the
// eight-stage pipeline, in which every stage holds at most one item and
// loads whenever it is empty or its successor moves on, so a stalled output
// holds only as much as is needed and empty stages fill up behind it. The
// sine and cosine come from a constant quarter-wave table of
// 2^SINE_TABLE_BITS + 1 entries, read once for each through a registered
// port. The block holds no state between items and needs no clearing pass
// after reset.
`default_nettype none

module dual_three_phase_vsd_transform #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  vsd_pkg::in_item_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output vsd_pkg::out_item_t result
);
	import vsd_pkg::*;

	localparam int W   = SAMPLE_WIDTH;
	localparam int E_W = W + 2;     // 2a1 - b1 - c1 and a2 + b2 - 2c2
	localparam int D_W = W + 1;     // b1 - c1 and a2 - b2
	localparam int P_W = W + 16;    // differences scaled by sqrt(3)/2
	localparam int S_W = W + 17;    // alpha, beta, x and y in Q14
	localparam int M_W = S_W + TRIG_WIDTH;
	localparam int N_W = M_W + 1;
	localparam angle_t ANGLE_QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

	// ---- pipeline control -------------------------------------------------
	pipe_ctrl_t pipe;

	vsd_pipe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.result_stall (result_stall),
		.pipe         (pipe)
	);

	assign sample_stall = !pipe.en[0];
	assign result_valid = pipe.vld[NUM_STAGES-1];

	// ---- angle lookups: stages 1 to 3 -------------------------------------
	// The cosine is the sine a quarter turn ahead; the add wraps modulo one
	// turn.
	angle_t cos_angle;
	trig_t  sin_s3;
	trig_t  cos_s3;

	assign cos_angle = sample.rotor_angle + ANGLE_QUARTER;

	vsd_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_sin (
		.clk   (clk),
		.en    (pipe.en[2:0]),
		.angle (sample.rotor_angle),
		.value (sin_s3)
	);

	vsd_sine_rom #(.TABLE_BITS(SINE_TABLE_BITS)) u_cos (
		.clk   (clk),
		.en    (pipe.en[2:0]),
		.angle (cos_angle),
		.value (cos_s3)
	);

	// ---- stage 1: phase sums and differences ------------------------------
	logic signed [E_W-1:0] e1_s1;
	logic signed [E_W-1:0] e2_s1;
	logic signed [D_W-1:0] d1_s1;
	logic signed [D_W-1:0] d2_s1;

	always_ff @(posedge clk) begin
		if (pipe.en[0]) begin
			e1_s1 <= (E_W'(sample.first_a_current) <<< 1)
				- E_W'(sample.first_b_current) - E_W'(sample.first_c_current);
			e2_s1 <= E_W'(sample.second_a_current) + E_W'(sample.second_b_current)
				- (E_W'(sample.second_c_current) <<< 1);
			d1_s1 <= D_W'(sample.first_b_current) - D_W'(sample.first_c_current);
			d2_s1 <= D_W'(sample.second_a_current) - D_W'(sample.second_b_current);
		end
	end

	// ---- stage 2: scale the differences by sqrt(3)/2 ----------------------
	logic signed [E_W-1:0] e1_s2;
	logic signed [E_W-1:0] e2_s2;
	logic signed [P_W-1:0] diff1_s2;
	logic signed [P_W-1:0] diff2_s2;

	always_ff @(posedge clk) begin
		if (pipe.en[1]) begin
			e1_s2    <= e1_s1;
			e2_s2    <= e2_s1;
			diff1_s2 <= P_W'(d1_s1) * P_W'(ROOT3_HALF_Q14);
			diff2_s2 <= P_W'(d2_s1) * P_W'(ROOT3_HALF_Q14);
		end
	end

	// ---- stage 3: stationary fundamental and harmonic planes --------------
	// Halving in Q14 is a shift of the doubled sums by one less place.
	logic signed [S_W-1:0] common;
	logic signed [S_W-1:0] rest;
	logic signed [S_W-1:0] alpha_s3;
	logic signed [S_W-1:0] beta_s3;
	logic signed [S_W-1:0] xs_s3;
	logic signed [S_W-1:0] ys_s3;

	assign common = S_W'(e1_s2) <<< HALF_Q14_SHIFT;
	assign rest   = S_W'(e2_s2) <<< HALF_Q14_SHIFT;

	always_ff @(posedge clk) begin
		if (pipe.en[2]) begin
			alpha_s3 <= common + S_W'(diff2_s2);
			beta_s3  <= S_W'(diff1_s2) + rest;
			xs_s3    <= common - S_W'(diff2_s2);
			ys_s3    <= rest - S_W'(diff1_s2);
		end
	end

	// ---- stage 4: rotate by the angle -------------------------------------
	logic signed [M_W-1:0] pca_s4;
	logic signed [M_W-1:0] psb_s4;
	logic signed [M_W-1:0] pcb_s4;
	logic signed [M_W-1:0] psa_s4;
	logic signed [S_W-1:0] xs_s4;
	logic signed [S_W-1:0] ys_s4;

	always_ff @(posedge clk) begin
		if (pipe.en[3]) begin
			pca_s4 <= M_W'(cos_s3) * M_W'(alpha_s3);
			psb_s4 <= M_W'(sin_s3) * M_W'(beta_s3);
			pcb_s4 <= M_W'(cos_s3) * M_W'(beta_s3);
			psa_s4 <= M_W'(sin_s3) * M_W'(alpha_s3);
			xs_s4  <= xs_s3;
			ys_s4  <= ys_s3;
		end
	end

	// ---- stage 5: combine the rotated products ----------------------------
	logic signed [N_W-1:0] dr_s5;
	logic signed [N_W-1:0] qr_s5;
	logic signed [S_W-1:0] xs_s5;
	logic signed [S_W-1:0] ys_s5;

	always_ff @(posedge clk) begin
		if (pipe.en[4]) begin
			dr_s5 <= N_W'(pca_s4) + N_W'(psb_s4);
			qr_s5 <= N_W'(pcb_s4) - N_W'(psa_s4);
			xs_s5 <= xs_s4;
			ys_s5 <= ys_s4;
		end
	end

	// ---- stages 6 to 8: divide by three, round, saturate ------------------
	// d and q carry 29 fraction bits (Q15 trig times Q14), x and y carry 14.
	sample_t d_out;
	sample_t q_out;
	sample_t x_out;
	sample_t y_out;

	vsd_round_div3 #(.NUM_WIDTH(N_W), .FRAC_BITS(29)) u_div_d (
		.clk (clk), .en (pipe.en[7:5]), .num (dr_s5), .result (d_out)
	);

	vsd_round_div3 #(.NUM_WIDTH(N_W), .FRAC_BITS(29)) u_div_q (
		.clk (clk), .en (pipe.en[7:5]), .num (qr_s5), .result (q_out)
	);

	vsd_round_div3 #(.NUM_WIDTH(S_W), .FRAC_BITS(14)) u_div_x (
		.clk (clk), .en (pipe.en[7:5]), .num (xs_s5), .result (x_out)
	);

	vsd_round_div3 #(.NUM_WIDTH(S_W), .FRAC_BITS(14)) u_div_y (
		.clk (clk), .en (pipe.en[7:5]), .num (ys_s5), .result (y_out)
	);

	assign result.d_current = d_out;
	assign result.q_current = q_out;
	assign result.x_current = x_out;
	assign result.y_current = y_out;

	// ---- checks -----------------------------------------------------------
	// Input is held back only when every stage is full behind a stalled output.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> ((&pipe.vld) && result_stall))
		else $error("input stalled while the pipeline has an empty stage");

	// An accepted item occupies the first stage on the next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> pipe.vld[0])
		else $error("accepted item did not enter the first stage");

	// Table values never reach the negative full-scale code.
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		pipe.vld[2] |-> ((sin_s3 != SAT_MIN) && (cos_s3 != SAT_MIN)))
		else $error("sine or cosine out of range");

	// The stage before the output keeps its item while its successor is blocked.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe.vld[NUM_STAGES-2] && !pipe.en[NUM_STAGES-2]) |=> pipe.vld[NUM_STAGES-2])
		else $error("held item dropped from the stage before the output");

endmodule

`default_nettype wire

// ===== dv/vsd_current_checker.sv =====
// ----------------------------------------------------------------------------
// vsd_current_checker: scoreboard for the dual three-phase VSD transform
// Watches both channels, works out the d/q/x/y currents of every accepted
// sample and compares each result item, in order, with its prediction.
// ----------------------------------------------------------------------------

module vsd_current_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  vsd_pkg::in_item_t  sample,
	input  logic               result_valid,
	input  logic               result_stall,
	input  vsd_pkg::out_item_t result,
	output int                 failures,
	output int                 outstanding,
	output int                 results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import vsd_pkg::*;

	localparam int TABLE_BITS = 10;
	localparam int TABLE_SIZE = 1 << TABLE_BITS;
	localparam longint QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint ROOT3_HALF = 14189;
	localparam longint ONE_Q14 = 16384;
	localparam longint HALF_Q14 = 8192;
	localparam longint PEAK = 32767;
	localparam int REPORT_LIMIT = 10;

	int quarter_wave [0:TABLE_SIZE];
	out_item_t expected_currents [$];

	// seven-term Taylor series of the quarter sine, unsigned Q30, truncating
	function automatic int taylor_entry(input int k);
		longint unsigned ph;
		longint unsigned ph2;
		longint unsigned t;
		longint unsigned den;
		longint acc;
		longint v;
		int n;
		ph = (longint'(k) * QUARTER_TURN_Q30) >> TABLE_BITS;
		ph2 = (ph * ph) >> 30;
		t = ph;
		acc = longint'(ph);
		for (n = 1; n <= 6; n++) begin
			den = (2 * n) * (2 * n + 1);
			t = ((t * ph2) >> 30) / den;
			if (n % 2 == 1) begin
				acc = acc - longint'(t);
			end else begin
				acc = acc + longint'(t);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = (acc * PEAK + (longint'(1) <<< 29)) >>> 30;
		if (v > PEAK) begin
			v = PEAK;
		end
		return int'(v);
	endfunction

	function automatic longint sine_q15(input angle_t ang);
		logic [1:0] quad;
		int idx;
		longint v;
		quad = ang[ANGLE_WIDTH-1 -: 2];
		idx = int'(ang[ANGLE_WIDTH-3 -: TABLE_BITS]);
		if (quad[0]) begin
			idx = TABLE_SIZE - idx;
		end
		v = quarter_wave[idx];
		return quad[1] ? -v : v;
	endfunction

	// divide by three and drop the fraction bits, ties away from zero
	function automatic longint round_third(input longint num, input int frac);
		longint unsigned den;
		longint unsigned mag;
		longint unsigned q;
		den = longint'(3) << frac;
		mag = (num < 0) ? -num : num;
		q = (mag + (den >> 1)) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic sample_t clamp_q15(input longint v);
		if (v > longint'(SAT_MAX)) begin
			return SAT_MAX;
		end
		if (v < longint'(SAT_MIN)) begin
			return SAT_MIN;
		end
		return sample_t'(v);
	endfunction

	function automatic out_item_t predict_currents(input in_item_t s);
		longint a1, b1, c1, a2, b2, c2;
		longint sn, cs;
		longint common, diff1, diff2, rest;
		longint alpha, beta;
		angle_t cos_ang;
		out_item_t r;
		a1 = s.first_a_current;
		b1 = s.first_b_current;
		c1 = s.first_c_current;
		a2 = s.second_a_current;
		b2 = s.second_b_current;
		c2 = s.second_c_current;
		cos_ang = s.rotor_angle + angle_t'(1 << (ANGLE_WIDTH - 2));
		sn = sine_q15(s.rotor_angle);
		cs = sine_q15(cos_ang);
		common = a1 * ONE_Q14 - (b1 + c1) * HALF_Q14;
		diff2 = (a2 - b2) * ROOT3_HALF;
		diff1 = (b1 - c1) * ROOT3_HALF;
		rest = (a2 + b2) * HALF_Q14 - c2 * ONE_Q14;
		alpha = common + diff2;
		beta = diff1 + rest;
		r.d_current = clamp_q15(round_third(cs * alpha + sn * beta, 29));
		r.q_current = clamp_q15(round_third(cs * beta - sn * alpha, 29));
		r.x_current = clamp_q15(round_third(common - diff2, 14));
		r.y_current = clamp_q15(round_third(rest - diff1, 14));
		return r;
	endfunction

	initial begin
		failures = 0;
		outstanding = 0;
		results_checked = 0;
		for (int k = 0; k <= TABLE_SIZE; k++) begin
			quarter_wave[k] = taylor_entry(k);
		end
	end

	// retire results before queueing this edge's sample
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_currents.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("%t unexpected result d=%0d q=%0d x=%0d y=%0d", $realtime,
							result.d_current, result.q_current, result.x_current,
							result.y_current);
					end
				end else begin
					want = expected_currents.pop_front();
					results_checked++;
					if (result.d_current !== want.d_current ||
							result.q_current !== want.q_current ||
							result.x_current !== want.x_current ||
							result.y_current !== want.y_current) begin
						failures++;
						if (failures <= REPORT_LIMIT) begin
							$display("%t result %0d: expected d=%0d q=%0d x=%0d y=%0d, got d=%0d q=%0d x=%0d y=%0d",
								$realtime, results_checked, want.d_current, want.q_current,
								want.x_current, want.y_current, result.d_current,
								result.q_current, result.x_current, result.y_current);
						end
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				expected_currents.push_back(predict_currents(sample));
			end
			outstanding <= expected_currents.size();
		end
	end

endmodule

// ===== dv/tb_dual_three_phase_vsd_transform.sv =====
// ----------------------------------------------------------------------------
// tb_dual_three_phase_vsd_transform: testbench of the dual three-phase VSD
// Drives directed and random phase-current samples through the transform
// under four idling mixes and one long output hold-off; a checker module
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module tb_dual_three_phase_vsd_transform;
	timeunit 1ns;
	timeprecision 1ps;

	import vsd_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 8;
	localparam int PHASE_ITEMS = 450;
	localparam int HOLD_OFF_CYCLES = 300;
	// eight register stages, plus slack for any stray result
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 400000;
	localparam int NUM_PHASES = 4;
	// idle and stall percentages of each random phase
	localparam int SEND_IDLE [NUM_PHASES] = '{0, 64, 0, 20};
	localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 64, 20};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      sample_valid;
	logic      sample_stall;
	in_item_t  sample;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	logic sample_taken = 1'b0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   samples_sent = 0;
	int   failures;
	int   outstanding;
	int   results_checked;

	always #(CLK_PERIOD / 2) clk = ~clk;

	dual_three_phase_vsd_transform dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	vsd_current_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.failures        (failures),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// Record the handshake with the values present just before the edge, so
	// the driver never races the block's own register updates.
	always @(posedge clk) begin
		sample_taken <= sample_valid && !sample_stall;
	end

	// Receiver: random stalls at the current phase's rate; on request, hold
	// the output off for a long stretch counted here, so the pipeline fills
	// and the block has to stall its input.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog: fail the run if the traffic never drains.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timed out with %0d results still awaited", outstanding);
		$display("[dual_three_phase_vsd_transform] ERROR");
		$finish;
	end

	function automatic in_item_t make_sample(input sample_t a1, input sample_t b1,
			input sample_t c1, input sample_t a2, input sample_t b2, input sample_t c2,
			input angle_t ang);
		in_item_t s;
		s.first_a_current = a1;
		s.first_b_current = b1;
		s.first_c_current = c1;
		s.second_a_current = a2;
		s.second_b_current = b2;
		s.second_c_current = c2;
		s.rotor_angle = ang;
		return s;
	endfunction

	// Mostly full-range currents, with a share of small values and of the
	// extremes where saturation and rounding edges live.
	function automatic sample_t pick_current();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 6) begin
			return sample_t'($urandom);
		end else if (sel < 8) begin
			return sample_t'(int'($urandom_range(2000)) - 1000);
		end
		case ($urandom_range(4))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return sample_t'(0);
			3: return sample_t'(-1);
			default: return sample_t'(1);
		endcase
	endfunction

	// Uniform angles, plus some hugging a quadrant boundary.
	function automatic angle_t pick_angle();
		if ($urandom_range(3) != 0) begin
			return angle_t'($urandom);
		end
		return angle_t'(int'($urandom_range(3)) * 16384 + int'($urandom_range(6)) - 3);
	endfunction

	function automatic in_item_t random_sample();
		return make_sample(pick_current(), pick_current(), pick_current(), pick_current(),
			pick_current(), pick_current(), pick_angle());
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is
	// taken. Idle cycles drop valid and scramble the payload.
	task automatic offer_sample(input in_item_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			sample <= random_sample();
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(negedge clk);
		while (!sample_taken) begin
			@(negedge clk);
		end
		samples_sent++;
	endtask

	task automatic run_directed();
		angle_t ang;
		// zeros, lone phase, all at each rail
		offer_sample(make_sample(0, 0, 0, 0, 0, 0, 16'h0000));
		offer_sample(make_sample(SAT_MAX, 0, 0, 0, 0, 0, 16'h0000));
		offer_sample(make_sample(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 16'h4000));
		offer_sample(make_sample(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 16'h8000));
		// alpha at its largest and smallest: d saturates both ways
		offer_sample(make_sample(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, 16'h0000));
		offer_sample(make_sample(SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, 16'h0000));
		// x saturates both ways
		offer_sample(make_sample(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, 0, 16'h2000));
		offer_sample(make_sample(SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, 0, 16'hA000));
		// y saturates both ways
		offer_sample(make_sample(0, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, 16'h6000));
		offer_sample(make_sample(0, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, 16'hE000));
		// beta at its largest and smallest, at a quarter and three-quarter turn: d follows the sine
		offer_sample(make_sample(0, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, 16'h4000));
		offer_sample(make_sample(0, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, 16'hC000));
		// unit and minus-one currents
		offer_sample(make_sample(1, -1, 1, -1, 1, -1, 16'h1234));
		offer_sample(make_sample(-1, -1, -1, -1, -1, -1, 16'hFFFF));
		// angles around the quadrant seams and the ends of the table
		foreach (SEND_IDLE[i]) begin
			ang = angle_t'(i * 16384);
			offer_sample(make_sample(16000, -8000, -8000, 13856, -13856, 0, ang - 1));
			offer_sample(make_sample(16000, -8000, -8000, 13856, -13856, 0, ang + 1));
		end
		offer_sample(make_sample(12000, -3000, -9000, 5000, 7000, -12000, 16'h000F));
		offer_sample(make_sample(-12000, 3000, 9000, -5000, -7000, 12000, 16'h3FF0));
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct = SEND_IDLE[p];
			stall_pct = RECV_STALL[p];
			// first phase opens with a long hold-off while items keep coming
			if (p == 0) begin
				hold_requests++;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer_sample(random_sample());
			end
		end
		sample_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d samples (directed rails, saturation, quadrant seams, then random)",
			samples_sent);
		$display("%0d results checked over four idle/stall mixes and a %0d-cycle hold-off",
			results_checked, HOLD_OFF_CYCLES);
		if (failures == 0 && outstanding == 0) begin
			$display("[dual_three_phase_vsd_transform] OK");
		end else begin
			$display("[dual_three_phase_vsd_transform] ERROR");
		end
		$finish;
	end

endmodule
